[hdl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console writer package
// Shared types, op codes and constants of the character-cell text console.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	localparam logic [7:0] TEXT_COLOR_RESET = 8'd11;
	localparam logic [7:0] SPACE_CODE       = 8'd32;
	localparam logic [7:0] NEWLINE_CODE     = 8'd10;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUT,
		ST_READ,
		ST_READ_WAIT,
		ST_SCROLL,
		ST_SCROLL_END,
		ST_FILL,
		ST_DONE
	} tcw_state_t;

endpackage

[hdl/text_console_writer_core.sv]
// ----------------------------------------------------------------------------
// Text console writer core
// Character-cell screen store with a cursor: put, read cell and clear ops,
// with line wrap, newline and scroll-up handled by a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  s_*     | in        | s_tvalid / s_tready | s_tuser op, s_tdata code/col/row
//  m_*     | out       | m_tvalid / m_tready | m_tdata cell/cursor col/cursor row
//  cfg_*   | in        | cfg_valid/cfg_ready | cfg_data text color attribute
//
// One request is taken at a time; s_tready is high only when the
// sequencer is idle. A put passes through ST_PUT, a read through ST_READ and
// ST_READ_WAIT (straight to ST_DONE when out of range or for an unused op).
// A clear sweeps the screen memory, one cell a cycle. A put that scrolls
// also copies one cell a cycle through the single read and write port,
// then blanks one row. Reset clears the cursor and the handshake state and
// sets the color register to TEXT_COLOR_RESET; the screen memory holds
// garbage until a clear op. A stalled m_tready holds the result register
// and the sequencer waits in its last state.
// ----------------------------------------------------------------------------
module text_console_writer_core
	import tcw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] char_code, [14:8] cell_col, [19:15] cell_row
	input  logic [1:0]  s_tuser,   // [1:0] op
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] cell_data, [22:16] cursor_col, [27:23] cursor_row
	// color register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	localparam int N  = COLUMNS * ROWS;
	localparam int AW = $clog2(N);
	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS);

	localparam logic [AW-1:0] LAST_ADDR     = AW'(N - 1);
	localparam logic [AW-1:0] SECOND_ROW    = AW'(COLUMNS);
	localparam logic [AW-1:0] BLANK_FIRST   = AW'(N - 2 * COLUMNS);
	localparam logic [AW-1:0] BLANK_LAST    = AW'(N - COLUMNS - 1);
	localparam logic [RW-1:0] LAST_ROW      = RW'(ROWS - 1);
	localparam logic [RW-1:0] PARK_ROW      = RW'(ROWS - 2);
	localparam logic [RW:0]   LAST_ROW_WIDE = (RW + 1)'(ROWS - 1);
	localparam logic [CW:0]   COLS_WIDE     = (CW + 1)'(COLUMNS);

	tcw_state_t state_q, state_d;

	// control state
	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;
	logic [AW-1:0] addr_q, addr_d;
	logic [AW-1:0] fill_end_q, fill_end_d;
	logic          resume_q, resume_d;
	logic          copy_s1, copy_d;
	logic          out_valid_q;
	logic [7:0]    color_q;

	// payload
	logic [7:0]    code_q;
	logic [AW-1:0] rd_addr_q;
	logic [15:0]   cell_q, cell_d;
	logic [AW-1:0] copy_addr_s1, copy_addr_d;
	logic [15:0]   rd_data_q;
	logic [31:0]   out_data_q;

	// screen memory
	logic [15:0]   screen_mem [N];
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem_wdata;

	logic          s_accept;
	logic          out_load;
	logic [6:0]    in_col;
	logic [4:0]    in_row;
	logic          in_rd_ok;
	logic [AW-1:0] in_rd_addr;
	logic [CW-1:0] eff_col;
	logic [CW:0]   col_inc;
	logic [RW:0]   row_inc;
	logic [AW-1:0] put_addr;
	logic [15:0]   blank_cell;
	logic [CW+6:0] col_out_wide;
	logic [RW+4:0] row_out_wide;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// request decode for the read op
	assign in_col     = s_tdata[14:8];
	assign in_row     = s_tdata[19:15];
	assign in_rd_ok   = ({2'b00, in_col} < 9'(COLUMNS)) && ({3'b000, in_row} < 8'(ROWS));
	assign in_rd_addr = AW'(in_row) * AW'(COLUMNS) + AW'(in_col);

	// cursor arithmetic for put
	assign eff_col    = ({1'b0, col_q} >= COLS_WIDE) ? '0 : col_q;
	assign col_inc    = {1'b0, eff_col} + (CW + 1)'(1);
	assign row_inc    = {1'b0, row_q} + (RW + 1)'(1);
	assign put_addr   = AW'(row_q) * AW'(COLUMNS) + AW'(eff_col);
	assign blank_cell = {color_q, SPACE_CODE};

	// mask the cursor to the result field widths
	assign col_out_wide = {7'b0, col_q};
	assign row_out_wide = {5'b0, row_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			addr_q      <= '0;
			fill_end_q  <= '0;
			resume_q    <= 1'b0;
			copy_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			color_q     <= TEXT_COLOR_RESET;
		end else begin
			state_q    <= state_d;
			col_q      <= col_d;
			row_q      <= row_d;
			addr_q     <= addr_d;
			fill_end_q <= fill_end_d;
			resume_q   <= resume_d;
			copy_s1    <= copy_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				color_q <= cfg_data;
			end
		end
	end

	// hold the request fields and the pipeline of the copy
	always_ff @(posedge clk) begin
		if (s_accept) begin
			code_q    <= s_tdata[7:0];
			rd_addr_q <= in_rd_addr;
		end
		cell_q       <= cell_d;
		copy_addr_s1 <= copy_addr_d;
		if (out_load) begin
			out_data_q <= {4'b0000, row_out_wide[4:0], col_out_wide[6:0], cell_q};
		end
	end

	// screen memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			screen_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= screen_mem[mem_raddr];
	end

	always_comb begin
		state_d     = state_q;
		col_d       = col_q;
		row_d       = row_q;
		addr_d      = addr_q;
		fill_end_d  = fill_end_q;
		resume_d    = resume_q;
		cell_d      = cell_q;
		copy_d      = 1'b0;
		copy_addr_d = copy_addr_s1;
		out_load    = 1'b0;
		mem_raddr   = addr_q;
		// a copy read in the previous cycle lands here
		mem_we      = copy_s1;
		mem_waddr   = copy_addr_s1;
		mem_wdata   = rd_data_q;

		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cell_d   = '0;
					resume_d = 1'b0;
					unique case (s_tuser)
						OP_PUT: begin
							state_d = ST_PUT;
						end
						OP_READ: begin
							state_d = in_rd_ok ? ST_READ : ST_DONE;
						end
						OP_CLEAR: begin
							addr_d     = '0;
							fill_end_d = LAST_ADDR;
							state_d    = ST_FILL;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end

			ST_PUT: begin
				if (row_q >= LAST_ROW) begin
					// cursor parked on the bottom row: scroll, then retry
					resume_d = 1'b1;
					addr_d   = SECOND_ROW;
					state_d  = ST_SCROLL;
				end else if (code_q == NEWLINE_CODE) begin
					col_d = '0;
					row_d = row_inc[RW-1:0];
					if (row_inc >= LAST_ROW_WIDE) begin
						addr_d  = SECOND_ROW;
						state_d = ST_SCROLL;
					end else begin
						state_d = ST_DONE;
					end
				end else begin
					mem_we    = 1'b1;
					mem_waddr = put_addr;
					mem_wdata = {color_q, code_q};
					if (col_inc >= COLS_WIDE) begin
						// wrap to the next line
						col_d = '0;
						row_d = row_inc[RW-1:0];
						if (row_inc >= LAST_ROW_WIDE) begin
							addr_d  = SECOND_ROW;
							state_d = ST_SCROLL;
						end else begin
							state_d = ST_DONE;
						end
					end else begin
						col_d   = col_inc[CW-1:0];
						state_d = ST_DONE;
					end
				end
			end

			ST_READ: begin
				mem_raddr = rd_addr_q;
				state_d   = ST_READ_WAIT;
			end

			ST_READ_WAIT: begin
				cell_d  = rd_data_q;
				state_d = ST_DONE;
			end

			ST_SCROLL: begin
				// read a cell one row down, write it one row up next cycle
				copy_d      = 1'b1;
				copy_addr_d = addr_q - SECOND_ROW;
				if (addr_q == LAST_ADDR) begin
					state_d = ST_SCROLL_END;
				end else begin
					addr_d = addr_q + AW'(1);
				end
			end

			ST_SCROLL_END: begin
				// drain the last copy, then blank the row above the bottom
				row_d      = PARK_ROW;
				addr_d     = BLANK_FIRST;
				fill_end_d = BLANK_LAST;
				state_d    = ST_FILL;
			end

			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = addr_q;
				mem_wdata = blank_cell;
				if (addr_q == fill_end_q) begin
					resume_d = 1'b0;
					state_d  = resume_q ? ST_PUT : ST_DONE;
				end else begin
					addr_d = addr_q + AW'(1);
				end
			end

			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[tb/text_console_writer_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer core testbench
// Drives put, read, clear and unused-op requests into the console core and
// checks every result against a cycle-free model of the screen store, the
// cursor and the color register. Both stream sides idle at random, the
// result side holds off for a long stretch, and the color register is
// rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
module text_console_writer_core_test;
	import tcw_pkg::*;

	localparam int SCREEN_COLS = DEF_COLUMNS;
	localparam int SCREEN_ROWS = DEF_ROWS;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Worst item: a put that scrolls, or a clear, plus generous stall slack.
	localparam int MAX_ITEMS   = 700;
	localparam int ITEM_WORST  = 2 * SCREEN_COLS * SCREEN_ROWS + 64;
	localparam int CYCLE_LIMIT = 3 * MAX_ITEMS * ITEM_WORST;
	localparam int TAIL_CYCLES = 16;

	typedef struct packed {
		logic [15:0] cell_data;
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
	} console_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data  = '0;

	// Screen model, cursor and color register as the core should hold them.
	logic [15:0] screen_model [SCREEN_COLS * SCREEN_ROWS];
	logic [6:0]  cursor_col_q = '0;
	logic [4:0]  cursor_row_q = '0;
	logic [7:0]  color_q      = TEXT_COLOR_RESET;
	bit          screen_known = 1'b0;

	console_result_t pending_results [$];
	int  fail_count  = 0;
	int  cycle_count = 0;
	int  rx_hold_len = 0;
	int  rx_hold_seq = 0;
	bit  tx_idle_en  = 1'b1;
	bit  rx_idle_en  = 1'b1;

	text_console_writer_core #(
		.COLUMNS(SCREEN_COLS),
		.ROWS(SCREEN_ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),     // [7:0] char_code, [14:8] cell_col, [19:15] cell_row
		.s_tuser(s_tuser),     // [1:0] op
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),     // [15:0] cell_data, [22:16] cursor_col, [27:23] cursor_row
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Screen model
	// ------------------------------------------------------------------
	function automatic int cell_index(input logic [6:0] col, input logic [4:0] row);
		return int'(row) * SCREEN_COLS + int'(col);
	endfunction

	// Move rows up by one, blank the row above the bottom and park there.
	function automatic void scroll_screen();
		for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
			screen_model[i] = screen_model[i + SCREEN_COLS];
		cursor_row_q = 5'(SCREEN_ROWS - 2);
		for (int c = 0; c < SCREEN_COLS; c++)
			screen_model[(SCREEN_ROWS - 2) * SCREEN_COLS + c] = {color_q, SPACE_CODE};
	endfunction

	function automatic void next_line();
		cursor_col_q = '0;
		cursor_row_q = cursor_row_q + 1'b1;
		if (cursor_row_q >= SCREEN_ROWS - 1)
			scroll_screen();
	endfunction

	function automatic void put_char(input logic [7:0] code);
		if (cursor_row_q >= SCREEN_ROWS - 1)
			scroll_screen();
		if (cursor_col_q >= SCREEN_COLS)
			cursor_col_q = '0;
		if (code == NEWLINE_CODE) begin
			next_line();
		end else begin
			screen_model[cell_index(cursor_col_q, cursor_row_q)] = {color_q, code};
			if (cursor_col_q == SCREEN_COLS - 1)
				next_line();
			else
				cursor_col_q = cursor_col_q + 1'b1;
		end
	endfunction

	function automatic console_result_t apply_request(input logic [1:0] op,
			input logic [7:0] code, input logic [6:0] col, input logic [4:0] row);
		console_result_t res;
		res.cell_data = '0;
		case (op)
			OP_PUT: begin
				put_char(code);
			end
			OP_READ: begin
				if (col < SCREEN_COLS && row < SCREEN_ROWS)
					res.cell_data = screen_model[cell_index(col, row)];
			end
			OP_CLEAR: begin
				for (int i = 0; i < SCREEN_COLS * SCREEN_ROWS; i++)
					screen_model[i] = {color_q, SPACE_CODE};
				screen_known = 1'b1;
			end
			default: begin
			end
		endcase
		res.cursor_col = cursor_col_q;
		res.cursor_row = cursor_row_q;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	// Offer one request, hold it until taken, then predict its result.
	task automatic send_request(input logic [1:0] op, input logic [7:0] code,
			input logic [6:0] col, input logic [4:0] row);
		int gap;
		gap = 0;
		if (tx_idle_en)
			while ($urandom_range(99) < 31)
				gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, row, col, code};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(apply_request(op, code, col, row));
	endtask

	// Drop valid and wait until every predicted result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_text_color(input logic [7:0] color);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= color;
		do @(posedge clk); while (!cfg_ready);
		color_q = color;
		cfg_valid <= 1'b0;
	endtask

	task automatic put_random_text(input int count);
		logic [7:0] code;
		for (int i = 0; i < count; i++) begin
			code = 8'($urandom_range(255));
			if (code == NEWLINE_CODE)
				code = NEWLINE_CODE + 1'b1;
			send_request(OP_PUT, code, 7'($urandom_range(127)), 5'($urandom_range(31)));
		end
	endtask

	// Read an in-range cell most of the time once the screen is known, else an out-of-range one.
	task automatic read_random_cell();
		logic [6:0] col;
		logic [4:0] row;
		col = 7'($urandom_range(127));
		row = 5'($urandom_range(31));
		if (screen_known && $urandom_range(9) != 0) begin
			col = 7'($urandom_range(SCREEN_COLS - 1));
			if ($urandom_range(1))
				row = cursor_row_q;
			else
				row = 5'($urandom_range(SCREEN_ROWS - 1));
		end else if ($urandom_range(1)) begin
			col = 7'($urandom_range(127, SCREEN_COLS));
		end else begin
			row = 5'($urandom_range(31, SCREEN_ROWS));
		end
		send_request(OP_READ, 8'($urandom_range(255)), col, row);
	endtask

	task automatic random_request();
		int pick;
		logic [7:0] code;
		pick = $urandom_range(99);
		code = 8'($urandom_range(255));
		if (pick < 62) begin
			if ($urandom_range(99) < 10)
				code = NEWLINE_CODE;
			send_request(OP_PUT, code, 7'($urandom_range(127)), 5'($urandom_range(31)));
		end else if (pick < 94) begin
			read_random_cell();
		end else if (pick < 97) begin
			send_request(OP_UNUSED, code, 7'($urandom_range(127)), 5'($urandom_range(31)));
		end else begin
			send_request(OP_CLEAR, code, 7'($urandom_range(127)), 5'($urandom_range(31)));
		end
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------
	// A new hold request is seen as a change of rx_hold_seq.
	always @(posedge clk) begin : result_sink
		int hold_left;
		int hold_seen;
		if (rx_hold_seq != hold_seen) begin
			hold_seen = rx_hold_seq;
			hold_left = rx_hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_idle_en) begin
			m_tready <= ($urandom_range(99) >= 31);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		console_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result, nothing pending: m_tdata %h", m_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[15:0] !== want.cell_data) begin
					$error("cell_data: expected %h actual %h", want.cell_data, m_tdata[15:0]);
					fail_count++;
				end
				if (m_tdata[22:16] !== want.cursor_col) begin
					$error("cursor_col: expected %0d actual %0d",
						want.cursor_col, m_tdata[22:16]);
					fail_count++;
				end
				if (m_tdata[27:23] !== want.cursor_row) begin
					$error("cursor_row: expected %0d actual %0d",
						want.cursor_row, m_tdata[27:23]);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("text_console_writer_core verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Before the first clear: puts, a newline, the unused op and reads that
	// fall off the screen; no in-range read touches the unwritten store.
	task automatic test_after_reset();
		send_request(OP_PUT, 8'h41, 7'd0, 5'd0);
		send_request(OP_PUT, NEWLINE_CODE, 7'd0, 5'd0);
		send_request(OP_UNUSED, 8'hFF, 7'h7F, 5'h1F);
		send_request(OP_READ, 8'h00, 7'h7F, 5'h1F);
		send_request(OP_READ, 8'h00, 7'(SCREEN_COLS), 5'd0);
		send_request(OP_READ, 8'h00, 7'd0, 5'(SCREEN_ROWS));
	endtask

	// Clear keeps the cursor; corners read back as blanks; code extremes.
	task automatic test_clear_and_read();
		send_request(OP_CLEAR, 8'hFF, 7'h7F, 5'h1F);
		send_request(OP_READ, 8'h00, 7'd0, 5'd0);
		send_request(OP_READ, 8'h00, 7'(SCREEN_COLS - 1), 5'd0);
		send_request(OP_READ, 8'h00, 7'd0, 5'(SCREEN_ROWS - 1));
		send_request(OP_READ, 8'h00, 7'(SCREEN_COLS - 1), 5'(SCREEN_ROWS - 1));
		send_request(OP_PUT, 8'h00, 7'd0, 5'd0);
		send_request(OP_PUT, 8'hFF, 7'd0, 5'd0);
		send_request(OP_READ, 8'h00, 7'd0, 5'd1);
		send_request(OP_READ, 8'h00, 7'd1, 5'd1);
	endtask

	task automatic test_text_color();
		logic [6:0] col;
		logic [4:0] row;
		write_text_color(8'h00);
		col = cursor_col_q;
		row = cursor_row_q;
		send_request(OP_PUT, 8'h78, 7'd0, 5'd0);
		send_request(OP_READ, 8'h00, col, row);
		write_text_color(8'hFF);
		col = cursor_col_q;
		row = cursor_row_q;
		send_request(OP_PUT, 8'h7E, 7'd0, 5'd0);
		send_request(OP_READ, 8'h00, col, row);
		send_request(OP_CLEAR, 8'h00, 7'd0, 5'd0);
		send_request(OP_READ, 8'h00, 7'd40, 5'd12);
	endtask

	// One full line back to back, no idling on either side.
	task automatic test_line_wrap();
		logic [4:0] row;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		send_request(OP_PUT, NEWLINE_CODE, 7'd0, 5'd0);
		row = cursor_row_q;
		put_random_text(SCREEN_COLS);
		send_request(OP_READ, 8'h00, 7'd0, row);
		send_request(OP_READ, 8'h00, 7'(SCREEN_COLS - 1), row);
		repeat (8)
			send_request(OP_READ, 8'h00, 7'($urandom_range(SCREEN_COLS - 1)), row);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// Walk down to the row above the bottom, then scroll by newline and by wrap.
	task automatic test_scroll();
		write_text_color(8'($urandom_range(255)));
		while (cursor_row_q != SCREEN_ROWS - 2)
			send_request(OP_PUT, NEWLINE_CODE, 7'($urandom_range(127)),
				5'($urandom_range(31)));
		repeat (3) begin
			put_random_text($urandom_range(1, 6));
			send_request(OP_PUT, NEWLINE_CODE, 7'd0, 5'd0);
			send_request(OP_READ, 8'h00, 7'($urandom_range(7)), 5'(SCREEN_ROWS - 3));
			send_request(OP_READ, 8'h00, 7'($urandom_range(SCREEN_COLS - 1)),
				5'(SCREEN_ROWS - 2));
			send_request(OP_READ, 8'h00, 7'($urandom_range(SCREEN_COLS - 1)),
				5'(SCREEN_ROWS - 1));
		end
		write_text_color(8'($urandom_range(255)));
		put_random_text(SCREEN_COLS);
		repeat (6)
			send_request(OP_READ, 8'h00, 7'($urandom_range(SCREEN_COLS - 1)),
				5'($urandom_range(SCREEN_ROWS - 1, SCREEN_ROWS - 4)));
	endtask

	// Hold the result side off while requests keep coming, then pause the
	// request side until everything is back.
	task automatic test_output_stall();
		rx_hold_len = 400;
		rx_hold_seq++;
		tx_idle_en = 1'b0;
		repeat (8)
			random_request();
		tx_idle_en = 1'b1;
		drain_results();
		repeat (4)
			random_request();
	endtask

	task automatic test_random_traffic();
		repeat (4) begin
			write_text_color(8'($urandom_range(255)));
			repeat (85)
				random_request();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_clear_and_read();
		test_text_color();
		test_line_wrap();
		test_scroll();
		test_output_stall();
		test_random_traffic();
		write_text_color(TEXT_COLOR_RESET);
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("text_console_writer_core verification clean");
		else
			$display("text_console_writer_core verification failed");
		$finish;
	end

endmodule

[files.f]
hdl/tcw_pkg.sv
hdl/text_console_writer_core.sv
tb/text_console_writer_core_test.sv
